FILE: rtl/core/kruskal_forest_edge_filter_defines.svh
// Assertion macros for the Kruskal forest edge filter.
// Included by the top level; depends on nothing else.
`ifndef KRUSKAL_FOREST_EDGE_FILTER_DEFINES_SVH
`define KRUSKAL_FOREST_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KFEF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfef: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KFEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfef: next-cycle check failed");

`endif

FILE: rtl/core/kfef_pkg.sv
// Shared widths, register indexes and reset values of the Kruskal forest edge filter.
// Used by the channel interfaces, the forest store and the top level.
`default_nettype none

package kfef_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int NODE_W     = 8;
  localparam int COST_W     = 16;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 32;
  localparam int RANK_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 1'd1;

  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST = 9'd256;
  localparam logic [CFG_DATA_W-1:0] TARGET_RST     = 9'd1;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

`default_nettype wire

FILE: rtl/core/kfef_if.sv
// Valid/ready channel interfaces for edge requests and filter results.
// Depends on kfef_pkg.
`default_nettype none

interface kfef_edge_if;
  import kfef_pkg::*;

  logic              valid;
  logic              ready;
  logic              first_edge;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [COST_W-1:0] edge_cost;

  modport source (output valid, first_edge, node_a, node_b, edge_cost, input ready);
  modport sink   (input valid, first_edge, node_a, node_b, edge_cost, output ready);
endinterface

interface kfef_result_if;
  import kfef_pkg::*;

  logic             valid;
  logic             ready;
  logic             kept;
  logic [CNT_W-1:0] removed_count;
  logic [SUM_W-1:0] removed_cost_total;

  modport source (output valid, kept, removed_count, removed_cost_total, input ready);
  modport sink   (input valid, kept, removed_count, removed_cost_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kfef_forest_store.sv
// Union-find parent and rank memory with per-entry valid bits.
// An entry never written since the last clear reads as its own root of rank zero.
// Depends on kfef_pkg.
`default_nettype none

module kfef_forest_store #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic [$clog2(DEPTH)-1:0]            rd_parent,
  output logic [kfef_pkg::RANK_W-1:0]         rd_rank,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic [$clog2(DEPTH)-1:0]            wr_parent,
  input  logic [kfef_pkg::RANK_W-1:0]         wr_rank
);
  import kfef_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0]     parent_mem [DEPTH];
  logic [RANK_W-1:0] rank_mem   [DEPTH];
  logic [DEPTH-1:0]  valid;

  logic [AW-1:0]     mem_parent_q;
  logic [RANK_W-1:0] mem_rank_q;
  logic [AW-1:0]     addr_q;
  logic              valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[wr_addr] <= wr_parent;
      rank_mem[wr_addr]   <= wr_rank;
    end
    mem_parent_q <= parent_mem[rd_addr];
    mem_rank_q   <= rank_mem[rd_addr];
    addr_q       <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_parent = valid_q ? mem_parent_q : addr_q;
  assign rd_rank   = valid_q ? mem_rank_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/kruskal_forest_edge_filter.sv
// Channel   | Dir | Contents
// ----------+-----+---------------------------------------------------------
// edges     | in  | first_edge, node_a, node_b, edge_cost (sorted by cost)
// results   | out | kept, removed_count, removed_cost_total (one per edge)
// cfg_*     | in  | write port: node_count (index 0), target_components (1)
//
// An edge that needs root walks passes through start, walk A and walk B, then
// link when it joins two trees and bump when the surviving root's rank grows,
// then finishing; the walks make one parent read per cycle from the single
// read port of the forest memory. An edge not walked goes straight to finishing.
// Reset is synchronous; an accepted first_edge clears all valid bits and counters.
// A result waits in the output register and stalls only the finishing step.
//
// Top level: sequencer, counters and forest store. Depends on kfef_pkg, kfef_if,
// kfef_forest_store and kruskal_forest_edge_filter_defines.svh.
`default_nettype none

`include "kruskal_forest_edge_filter_defines.svh"

module kruskal_forest_edge_filter #(
  parameter int MAX_NODES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kfef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kfef_pkg::CFG_DATA_W-1:0]   cfg_data,
  kfef_edge_if.sink                         edges,
  kfef_result_if.source                     results
);
  import kfef_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK_A,
    S_WALK_B,
    S_LINK,
    S_BUMP,
    S_FINISH
  } state_t;

  state_t state;

  logic [CFG_DATA_W-1:0] node_count;
  logic [CFG_DATA_W-1:0] target_components;

  logic [NW-1:0]     cur;
  logic [NW-1:0]     node_b_q;
  logic [COST_W-1:0] cost_q;
  logic [NW-1:0]     root_a;
  logic [RANK_W-1:0] rank_a;
  logic [NW-1:0]     root_b;
  logic [RANK_W-1:0] rank_b;
  logic              kept_q;
  logic [LW-1:0]     union_count;
  logic [CNT_W-1:0]  removed_counter;
  logic [SUM_W-1:0]  removed_sum;

  logic              out_valid;
  logic              out_kept;
  logic [CNT_W-1:0]  out_count;
  logic [SUM_W-1:0]  out_sum;

  logic [LW-1:0]     n_ext;
  logic [LW-1:0]     n_eff;
  logic [LW-1:0]     tgt_ext;
  logic [LW-1:0]     limit;
  logic [LW-1:0]     union_eff;
  logic              walk_ok;
  logic              in_accept;

  logic [NW-1:0]     rd_addr;
  logic [NW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic              wr_en;
  logic [NW-1:0]     wr_addr;
  logic [NW-1:0]     wr_parent;
  logic [RANK_W-1:0] wr_rank;
  logic              at_root;

  logic [CNT_W-1:0]  counter_next;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count        <= NODE_COUNT_RST;
      target_components <= TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count        <= cfg_data;
        REG_TARGET:     target_components <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    n_ext     = LW'(node_count);
    n_eff     = (n_ext > LW'(MAX_NODES)) ? LW'(MAX_NODES) : n_ext;
    tgt_ext   = LW'(target_components);
    limit     = (tgt_ext < n_eff) ? LW'(n_eff - tgt_ext) : '0;
    union_eff = edges.first_edge ? '0 : union_count;
    walk_ok   = (union_eff < limit) && (LW'(edges.node_a) < n_eff)
                && (LW'(edges.node_b) < n_eff);
  end

  assign edges.ready = (state == S_IDLE);
  assign in_accept   = edges.valid && (state == S_IDLE);
  assign at_root     = (rd_parent == cur);

  always_comb begin
    rd_addr = cur;
    case (state)
      S_WALK_A: rd_addr = at_root ? node_b_q : rd_parent;
      S_WALK_B: rd_addr = rd_parent;
      default:  rd_addr = cur;
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = root_a;
    wr_parent = root_b;
    wr_rank   = rank_a;
    if (state == S_LINK) begin
      wr_en = 1'b1;
      if (rank_a > rank_b) begin
        wr_addr   = root_b;
        wr_parent = root_a;
        wr_rank   = rank_b;
      end
    end else if (state == S_BUMP) begin
      wr_en     = 1'b1;
      wr_addr   = root_b;
      wr_parent = root_b;
      wr_rank   = RANK_W'(rank_b + 1'b1);
    end
  end

  kfef_forest_store #(
    .DEPTH(MAX_NODES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (in_accept && edges.first_edge),
    .rd_addr  (rd_addr),
    .rd_parent(rd_parent),
    .rd_rank  (rd_rank),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_parent(wr_parent),
    .wr_rank  (wr_rank)
  );

  always_comb begin
    sum_wide = {1'b0, removed_sum} + (SUM_W + 1)'(cost_q);
    if (kept_q) begin
      counter_next = removed_counter;
      sum_next     = removed_sum;
    end else begin
      counter_next = (&removed_counter) ? removed_counter : CNT_W'(removed_counter + 1'b1);
      sum_next     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
    out_free = !out_valid || results.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      union_count     <= '0;
      removed_counter <= '0;
      removed_sum     <= '0;
      kept_q          <= 1'b0;
    end else begin
      if (results.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (edges.valid) begin
            cur      <= NW'(edges.node_a);
            node_b_q <= NW'(edges.node_b);
            cost_q   <= edges.edge_cost;
            kept_q   <= 1'b0;
            if (edges.first_edge) begin
              union_count     <= '0;
              removed_counter <= '0;
              removed_sum     <= '0;
            end
            state <= walk_ok ? S_START : S_FINISH;
          end
        end
        S_START: begin
          state <= S_WALK_A;
        end
        S_WALK_A: begin
          if (at_root) begin
            root_a <= cur;
            rank_a <= rd_rank;
            cur    <= node_b_q;
            state  <= S_WALK_B;
          end else begin
            cur <= rd_parent;
          end
        end
        S_WALK_B: begin
          if (at_root) begin
            root_b <= cur;
            rank_b <= rd_rank;
            state  <= (cur == root_a) ? S_FINISH : S_LINK;
          end else begin
            cur <= rd_parent;
          end
        end
        S_LINK: begin
          kept_q      <= 1'b1;
          union_count <= LW'(union_count + 1'b1);
          if ((rank_a == rank_b) && (rank_b < RANK_MAX)) begin
            state <= S_BUMP;
          end else begin
            state <= S_FINISH;
          end
        end
        S_BUMP: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            removed_counter <= counter_next;
            removed_sum     <= sum_next;
            out_kept        <= kept_q;
            out_count       <= counter_next;
            out_sum         <= sum_next;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid              = out_valid;
  assign results.kept               = out_kept;
  assign results.removed_count      = out_count;
  assign results.removed_cost_total = out_sum;

  `KFEF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_accept, !edges.ready)
  `KFEF_ASSERT_NEXT(a_link_counts_union, clk, rst, state == S_LINK, union_count == LW'($past(union_count) + 1'b1))
  `KFEF_ASSERT_IMPL(a_result_from_finish, clk, rst, $rose(out_valid), $past(state == S_FINISH))
  `KFEF_ASSERT_IMPL(a_write_only_when_linking, clk, rst, wr_en, state == S_LINK || state == S_BUMP)

endmodule

`default_nettype wire
